>>> rtl/core/scp_pkg.sv
package scp_pkg;

   // Q8.24 working format
   localparam int Q_FRAC      = 24;
   localparam int FRAC_W      = 24;
   localparam int ANGLE_W     = 33;                  // angle plus cosine offset, no wrap
   localparam int TSCALE_W    = 23;
   localparam int ANG_PROD_W  = ANGLE_W + TSCALE_W;  // angle times turn scale
   localparam int Y_W         = 34;                  // Horner accumulator
   localparam int PROD_W      = Y_W + FRAC_W + 1;    // accumulator times signed multiplicand
   localparam int NUM_COEF    = 6;

   typedef logic signed [ANGLE_W-1:0]    angle_type;
   typedef logic signed [TSCALE_W-1:0]   tscale_type;
   typedef logic signed [ANG_PROD_W-1:0] angle_prod_type;
   typedef logic        [FRAC_W-1:0]     frac_type;
   typedef logic        [2*FRAC_W-1:0]   square_type;
   typedef logic signed [Y_W-1:0]        coef_type;
   typedef logic signed [PROD_W-1:0]     prod_type;

   localparam tscale_type TURN_SCALE = 23'sd2670178;
   localparam angle_type  COS_OFFSET = 33'sd26353651;

   // highest order first, the last one closes the f * P(f*f) product
   localparam coef_type HORNER_COEF [NUM_COEF] = '{
      -34'sd115409966,
       34'sd566658859,
      -34'sd1216779334,
       34'sd1352032217,
      -34'sd691905810,
       34'sd105373835
   };

   // Q16.48 product back to Q8.24, truncated toward zero
   function automatic coef_type trunc_q24(input prod_type p);
      prod_type bias;
      prod_type shifted;
      bias    = p[PROD_W-1] ? prod_type'({Q_FRAC{1'b1}}) : '0;
      shifted = (p + bias) >>> Q_FRAC;
      return shifted[Y_W-1:0];
   endfunction

endpackage

>>> rtl/core/scp_horner.sv
module scp_horner (
   input  logic              clock,
   input  logic              en,
   input  scp_pkg::prod_type m_i,
   input  scp_pkg::coef_type coef_i,
   input  scp_pkg::frac_type mul_i,
   output scp_pkg::prod_type m_ff
);
   import scp_pkg::*;

   coef_type y;
   prod_type m_in;

   // fold in the previous product, add the coefficient, multiply
   always_comb begin
      y    = trunc_q24(m_i) + coef_i;
      m_in = y * $signed({1'b0, mul_i});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff <= m_in;
      end
   end

endmodule

>>> rtl/core/sine_cosine_polynomial_approx_top.sv
// Fixed-point sine/cosine: each transaction carries a signed Q8.24 angle in radians and an
// action bit (0 sine, 1 cosine); the response is a signed Q1.OUT_FRAC_BITS value saturated
// to plus or minus one. The datapath is a ten-stage pipeline with at most one multiplier per
// stage: offset add, turn scaling, fraction and square, six Horner steps, then output
// truncation and clamp. A new transaction is taken every cycle while req_stall is low. Stall
// ripples backward only through stages that hold a transaction, so empty stages (bubbles)
// are squeezed out, and req_stall is high only when all ten stages are full and the response
// side is stalling.
module sine_cosine_polynomial_approx_top #(
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic signed [31:0]              req_angle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_value
);
   import scp_pkg::*;

   localparam int NUM_STG = 10;
   localparam int VALUE_W = OUT_FRAC_BITS + 2;
   localparam int SHIFT   = 2 * Q_FRAC - OUT_FRAC_BITS;  // Q16.48 down to output fraction
   localparam int HORNER0 = 3;                           // stage of the first Horner step
   localparam prod_type POS_LIM = prod_type'(1) <<< OUT_FRAC_BITS;
   localparam prod_type NEG_LIM = -POS_LIM;

   // ---------------------------------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or its content moves on.
   // ---------------------------------------------------------------------------------------
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG:0]   adv;

   assign adv[NUM_STG] = !rsp_stall;

   for (genvar k = 0; k < NUM_STG; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   assign req_stall = !adv[0];

   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 0: add the quarter-turn offset for cosine. 33 bits, so it never wraps.
   // ---------------------------------------------------------------------------------------
   angle_type a_ff;
   angle_type a_in;

   assign a_in = {req_angle[31], req_angle} + (req_action ? COS_OFFSET : angle_type'(0));

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff <= a_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1: scale radians to turns (Q8.24 times Q8.24 gives Q16.48).
   // ---------------------------------------------------------------------------------------
   angle_prod_type turn_ff;
   angle_prod_type turn_in;

   assign turn_in = a_ff * TURN_SCALE;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         turn_ff <= turn_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: truncate toward zero to Q8.24 and keep the fractional turn; square it.
   // The low bits of the two's complement word are x - floor(x), so negative
   // angles land in [0,1) as well.
   // ---------------------------------------------------------------------------------------
   angle_prod_type turn_bias;
   angle_prod_type turn_q24;
   frac_type       frac_in;
   square_type     sq_in;
   square_type     sq_ff;
   frac_type       frac_ff [2:HORNER0+4];
   frac_type       xx_ff   [HORNER0:HORNER0+3];

   always_comb begin
      turn_bias = turn_ff[ANG_PROD_W-1] ? angle_prod_type'({Q_FRAC{1'b1}}) : '0;
      turn_q24  = (turn_ff + turn_bias) >>> Q_FRAC;
      frac_in   = turn_q24[FRAC_W-1:0];
      sq_in     = frac_in * frac_in;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sq_ff <= sq_in;
      end
   end

   // Carry the fraction to the last Horner step and its square through the others.
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         frac_ff[2] <= frac_in;
      end
      for (int k = 3; k <= HORNER0 + 4; k++) begin
         if (adv[k]) begin
            frac_ff[k] <= frac_ff[k-1];
         end
      end
      if (adv[HORNER0]) begin
         xx_ff[HORNER0] <= sq_ff[2*FRAC_W-1:FRAC_W];
      end
      for (int k = HORNER0 + 1; k <= HORNER0 + 3; k++) begin
         if (adv[k]) begin
            xx_ff[k] <= xx_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stages 3..8: Horner steps. The first starts from a zero product so that its sum is the
   // top coefficient; the first five multiply by f*f, and the last multiplies by f.
   // ---------------------------------------------------------------------------------------
   prod_type hm [NUM_COEF];

   for (genvar j = 0; j < NUM_COEF; j++) begin : g_horner
      prod_type m_src;
      frac_type mul_src;

      if (j == 0) begin : g_first
         assign m_src   = '0;
         assign mul_src = sq_ff[2*FRAC_W-1:FRAC_W];
      end else if (j == NUM_COEF - 1) begin : g_last
         assign m_src   = hm[j-1];
         assign mul_src = frac_ff[HORNER0+j-1];
      end else begin : g_mid
         assign m_src   = hm[j-1];
         assign mul_src = xx_ff[HORNER0+j-1];
      end

      scp_horner u_horner (
         .clock  (clock),
         .en     (adv[HORNER0+j]),
         .m_i    (m_src),
         .coef_i (HORNER_COEF[j]),
         .mul_i  (mul_src),
         .m_ff   (hm[j])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Stage 9: one truncation toward zero straight to the output fraction (two successive
   // truncations toward zero equal one), then clamp to plus or minus one.
   // ---------------------------------------------------------------------------------------
   prod_type                  out_bias;
   prod_type                  out_shift;
   prod_type                  out_clamp;
   logic signed [VALUE_W-1:0] value_in;
   logic signed [VALUE_W-1:0] value_ff;

   always_comb begin
      out_bias  = hm[NUM_COEF-1][PROD_W-1] ? prod_type'({SHIFT{1'b1}}) : '0;
      out_shift = (hm[NUM_COEF-1] + out_bias) >>> SHIFT;
      if (out_shift > POS_LIM) begin
         out_clamp = POS_LIM;
      end else if (out_shift < NEG_LIM) begin
         out_clamp = NEG_LIM;
      end else begin
         out_clamp = out_shift;
      end
      value_in = out_clamp[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STG-1]) begin
         value_ff <= value_in;
      end
   end

   assign rsp_valid = vld_ff[NUM_STG-1];
   assign rsp_value = value_ff;

endmodule

>>> rtl/core/scp_checker.sv
module scp_checker #(
   parameter int OUT_FRAC_BITS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_action,
   input logic signed [31:0]              req_angle,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_value
);

   localparam logic signed [OUT_FRAC_BITS+1:0] POS_LIM =
      (OUT_FRAC_BITS+2)'(1) <<< OUT_FRAC_BITS;
   localparam logic signed [OUT_FRAC_BITS+1:0] NEG_LIM = -POS_LIM;

   // Hold a stalled request.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_action) && $stable(req_angle))
      else $error("stalled request changed");

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled response changed");

   // Saturated result stays within plus or minus one.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= POS_LIM) && (rsp_value >= NEG_LIM))
      else $error("response outside plus or minus one");

   // An empty output stage means every stage can advance.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the pipeline drains");

   // Drop everything on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sine_cosine_polynomial_approx_top scp_checker #(
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_scp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_action (req_action),
   .req_angle  (req_angle),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_value  (rsp_value)
);
